// ===== rtl/overlap_feather_blend_top_macros.svh =====
// Assertion macros shared by the overlap feather blend RTL.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef OVERLAP_FEATHER_BLEND_TOP_MACROS_SVH
`define OVERLAP_FEATHER_BLEND_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OFB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ofb_pkg.sv =====
// Package for the overlap feather blend block: widths, register indexes and types.
// Used by ofb_datapath and overlap_feather_blend_top; depends on nothing.
package ofb_pkg;

    localparam int ChanW   = 8;
    localparam int ColW    = 13;
    localparam int StartW  = 12;
    localparam int ThrW    = 8;
    localparam int ProdW   = 21;    // 255 * 8191 fits in 21 bits
    localparam int NumDiv  = ChanW; // one quotient bit per divider stage
    localparam int AddrW   = 4;
    localparam int DataW   = 32;
    localparam int InDataW  = 64;
    localparam int OutDataW = 24;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_OVERLAP_START  = 2'd0;
    localparam logic [1:0] REG_LEFT_WIDTH     = 2'd1;
    localparam logic [1:0] REG_DARK_THRESHOLD = 2'd2;

    typedef logic [ChanW-1:0] chan_t;
    typedef chan_t [2:0] pix_t;     // [0] blue, [1] green, [2] red
    typedef logic [ProdW-1:0] prod_t;

    typedef struct packed {
        logic [StartW-1:0] overlap_start;
        logic [ColW-1:0]   left_width;
        logic [ThrW-1:0]   dark_threshold;
    } cfg_t;

    typedef struct packed {
        logic [ColW-1:0] column;
        pix_t            left;
        pix_t            warp;
    } item_t;

endpackage

// ===== rtl/ofb_datapath.sv =====
// Pipelined compositing datapath: classify, weight multiply, restoring divide.
// Depends on ofb_pkg; instantiated by overlap_feather_blend_top.
module ofb_datapath #(
    parameter int COLUMN_BITS = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  ofb_pkg::item_t in_item,
    input  ofb_pkg::cfg_t  cfg,
    output logic          out_valid,
    output ofb_pkg::pix_t  out_pix
);

    localparam int NumDiv = ofb_pkg::NumDiv;
    localparam int ColW   = ofb_pkg::ColW;
    localparam logic [ColW-1:0] ColMask = (COLUMN_BITS >= ColW) ? {ColW{1'b1}} :
        ColW'((17'd1 << COLUMN_BITS) - 17'd1);

    localparam logic [1:0] MODE_LEFT  = 2'd0;
    localparam logic [1:0] MODE_WARP  = 2'd1;
    localparam logic [1:0] MODE_BLEND = 2'd2;

    // Stage 1: classification and overlap offsets.
    logic            v1_reg;
    logic [1:0]      mode1_reg, mode1_next;
    logic [ColW-1:0] d1_reg, d1_next;
    logic [ColW-1:0] wmd1_reg, wmd1_next;
    logic [ColW-1:0] w1_reg, w1_next;
    ofb_pkg::pix_t   left1_reg, warp1_reg;

    // Stage 2 is index 0 of the arrays below; divider stages are 1..NumDiv.
    logic [NumDiv:0]  vld_reg;
    ofb_pkg::prod_t [2:0] rem_reg [0:NumDiv];
    ofb_pkg::prod_t [2:0] rem_next [1:NumDiv];
    ofb_pkg::pix_t    q_reg [0:NumDiv];
    ofb_pkg::pix_t    q_next [1:NumDiv];
    logic [ColW-1:0]  w_reg [0:NumDiv-1];
    ofb_pkg::pix_t    pass_reg [0:NumDiv];
    logic [NumDiv:0]  blend_reg;

    ofb_pkg::prod_t [2:0] prod_next;
    ofb_pkg::pix_t        pass_next;

    always_comb
    begin
        logic [ColW-1:0] col;
        logic            beyond;
        logic            before_start;
        logic            dark;
        col          = in_item.column & ColMask;
        beyond       = col >= cfg.left_width;
        before_start = col < {1'b0, cfg.overlap_start};
        dark         = (in_item.warp[0] < cfg.dark_threshold) &&
                       (in_item.warp[1] < cfg.dark_threshold) &&
                       (in_item.warp[2] < cfg.dark_threshold);
        if (beyond)
            mode1_next = MODE_WARP;
        else if (before_start || dark)
            mode1_next = MODE_LEFT;
        else
            mode1_next = MODE_BLEND;
        d1_next   = col - {1'b0, cfg.overlap_start};
        wmd1_next = cfg.left_width - col;
        w1_next   = cfg.left_width - {1'b0, cfg.overlap_start};
    end

    // Stage 2: weighted sum per channel; the pass-through pixel is settled here.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_next[c] = ofb_pkg::ProdW'(left1_reg[c]) * ofb_pkg::ProdW'(wmd1_reg) +
                           ofb_pkg::ProdW'(warp1_reg[c]) * ofb_pkg::ProdW'(d1_reg);
        end
        case (mode1_reg)
            MODE_WARP: pass_next = warp1_reg;
            default:   pass_next = left1_reg;
        endcase
    end

    // Divider stages: stage s decides quotient bit NumDiv - s.
    always_comb
    begin
        ofb_pkg::prod_t dsh;
        logic           ge;
        for (int s = 1; s <= NumDiv; s++)
        begin
            dsh = ofb_pkg::ProdW'(w_reg[s-1]) << (NumDiv - s);
            for (int c = 0; c < 3; c++)
            begin
                ge = rem_reg[s-1][c] >= dsh;
                rem_next[s][c] = ge ? rem_reg[s-1][c] - dsh : rem_reg[s-1][c];
                q_next[s][c]   = q_reg[s-1][c] |
                                 (ge ? ofb_pkg::ChanW'(8'd1 << (NumDiv - s)) : '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            vld_reg <= '0;
        end
        else if (en)
        begin
            v1_reg  <= in_valid;
            vld_reg <= {vld_reg[NumDiv-1:0], v1_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg <= mode1_next;
            d1_reg    <= d1_next;
            wmd1_reg  <= wmd1_next;
            w1_reg    <= w1_next;
            left1_reg <= in_item.left;
            warp1_reg <= in_item.warp;

            rem_reg[0]   <= prod_next;
            q_reg[0]     <= '0;
            w_reg[0]     <= w1_reg;
            pass_reg[0]  <= pass_next;
            blend_reg[0] <= mode1_reg == MODE_BLEND;

            for (int s = 1; s <= NumDiv; s++)
            begin
                rem_reg[s]   <= rem_next[s];
                q_reg[s]     <= q_next[s];
                pass_reg[s]  <= pass_reg[s-1];
                blend_reg[s] <= blend_reg[s-1];
            end
            for (int s = 1; s < NumDiv; s++)
            begin
                w_reg[s] <= w_reg[s-1];
            end
        end
    end

    assign out_valid = vld_reg[NumDiv];
    assign out_pix   = blend_reg[NumDiv] ? q_reg[NumDiv] : pass_reg[NumDiv];

endmodule

// ===== rtl/overlap_feather_blend_top.sv =====
// Top level of the overlap feather blend compositor: stream ports, APB registers,
// output skid stage. Depends on ofb_pkg, ofb_datapath and the assertion macro header.
//
// Usage: each word on the slave stream carries one mosaic pixel: its column and a
// BGR pixel from the left image and from the warped right image. Each accepted word
// yields exactly one word on the master stream with the composited BGR pixel, in
// the same order. Columns before overlap_start pass the left pixel, columns at or
// past left_width pass the warped pixel, and columns in between are feathered
// linearly unless the warped pixel is dark, in which case the left pixel passes.
// The blend weight is divided out by a restoring divider with one quotient bit per
// pipeline stage, so the datapath is two stages of setup and multiply followed by
// eight divider stages. A result passes through these stages and then the output
// register before it appears on m_tvalid, and one word per cycle is accepted and
// delivered when the receiver keeps m_tready high.
// When the receiver stalls, the output register holds its word and one more word is
// caught in a skid register; then the whole pipeline freezes and s_tready drops,
// with no word lost or repeated. s_tready never depends on m_tready combinationally.
// Reset clears all valid bits and loads the registers with overlap_start 0,
// left_width 4096 and dark_threshold 50. Registers are written through the APB
// port at byte addresses 0, 4 and 8 and should only change while the block is idle.
`include "overlap_feather_blend_top_macros.svh"

module overlap_feather_blend_top #(
    parameter int COLUMN_BITS = 13
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Slave stream: column[12:0], left_blue[20:13], left_green[28:21],
    // left_red[36:29], warp_blue[44:37], warp_green[52:45], warp_red[60:53].
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ofb_pkg::InDataW-1:0]     s_tdata,
    // Master stream: out_blue[7:0], out_green[15:8], out_red[23:16].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ofb_pkg::OutDataW-1:0]    m_tdata,
    // APB configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ofb_pkg::AddrW-1:0]       paddr,
    input  logic [ofb_pkg::DataW-1:0]       pwdata,
    output logic [ofb_pkg::DataW-1:0]       prdata,
    output logic                            pready
);

    logic [ofb_pkg::StartW-1:0] overlap_start_reg;
    logic [ofb_pkg::ColW-1:0]   left_width_reg;
    logic [ofb_pkg::ThrW-1:0]   dark_threshold_reg;
    logic                       cfg_write;
    ofb_pkg::cfg_t              cfg;
    ofb_pkg::item_t             in_item;

    logic                       pipe_en;
    logic                       pipe_valid;
    ofb_pkg::pix_t              pipe_pix;

    logic                       m_valid_reg;
    ofb_pkg::pix_t              m_pix_reg;
    logic                       skid_valid_reg;
    ofb_pkg::pix_t              skid_pix_reg;
    logic                       out_free;
    logic                       pipe_fire;

    // Configuration registers. pready is tied high, so a write lands in the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_start_reg  <= '0;
            left_width_reg     <= 13'd4096;
            dark_threshold_reg <= 8'd50;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                ofb_pkg::REG_OVERLAP_START:  overlap_start_reg  <= pwdata[ofb_pkg::StartW-1:0];
                ofb_pkg::REG_LEFT_WIDTH:     left_width_reg     <= pwdata[ofb_pkg::ColW-1:0];
                ofb_pkg::REG_DARK_THRESHOLD: dark_threshold_reg <= pwdata[ofb_pkg::ThrW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ofb_pkg::REG_OVERLAP_START:  prdata = ofb_pkg::DataW'(overlap_start_reg);
            ofb_pkg::REG_LEFT_WIDTH:     prdata = ofb_pkg::DataW'(left_width_reg);
            ofb_pkg::REG_DARK_THRESHOLD: prdata = ofb_pkg::DataW'(dark_threshold_reg);
            default:                     prdata = '0;
        endcase
    end

    assign cfg.overlap_start  = overlap_start_reg;
    assign cfg.left_width     = left_width_reg;
    assign cfg.dark_threshold = dark_threshold_reg;

    // Unpack the input word.
    assign in_item.column  = s_tdata[12:0];
    assign in_item.left[0] = s_tdata[20:13];
    assign in_item.left[1] = s_tdata[28:21];
    assign in_item.left[2] = s_tdata[36:29];
    assign in_item.warp[0] = s_tdata[44:37];
    assign in_item.warp[1] = s_tdata[52:45];
    assign in_item.warp[2] = s_tdata[60:53];

    // The pipeline advances unless its last stage holds a word that the skid
    // register cannot take. Both terms are registers, so m_tready stays local.
    assign pipe_en   = !pipe_valid || !skid_valid_reg;
    assign s_tready  = pipe_en;
    assign pipe_fire = pipe_valid && !skid_valid_reg;

    ofb_datapath #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .cfg       (cfg),
        .out_valid (pipe_valid),
        .out_pix   (pipe_pix)
    );

    // Output register with one skid entry behind it.
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                m_valid_reg <= pipe_fire;
            end
        end
        else if (pipe_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                m_pix_reg <= skid_pix_reg;
            else if (pipe_fire)
                m_pix_reg <= pipe_pix;
        end
        else if (pipe_fire)
        begin
            skid_pix_reg <= pipe_pix;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pix_reg[2], m_pix_reg[1], m_pix_reg[0]};

    // A word in the skid register always sits behind a word in the output register.
    `OFB_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, m_valid_reg, "skid word without output word")
    // A taken output word is replaced at once by the skid word.
    `OFB_ASSERT_NEXT(a_skid_drains, skid_valid_reg && m_tready, m_valid_reg && !skid_valid_reg, "skid word not moved to output")
    // A word leaving the pipeline into a stalled output is caught by the skid register.
    `OFB_ASSERT_NEXT(a_stall_caught, m_valid_reg && !m_tready && pipe_valid && !skid_valid_reg, skid_valid_reg, "word lost during output stall")
    // A write to the overlap start register takes effect at the next edge.
    `OFB_ASSERT_NEXT(a_start_written, cfg_write && paddr[3:2] == ofb_pkg::REG_OVERLAP_START, overlap_start_reg == $past(pwdata[11:0]), "overlap start write not applied")

endmodule
